// ===== rtl/mlfq_scheduler_three_level_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef MLFQ_SCHEDULER_THREE_LEVEL_MACROS_SVH
`define MLFQ_SCHEDULER_THREE_LEVEL_MACROS_SVH
`ifndef SYNTHESIS
`define MLFQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MLFQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MLFQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define MLFQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/mlfq_pkg.sv =====
// Package with the constants, codes and types of the scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;

  localparam int NUM_SLOTS  = 64;
  localparam int FIFO_DEPTH = 64;
  localparam int SLOT_W     = 6;
  localparam int PTR_W      = 6;
  localparam int CNT_W      = 7;
  localparam int NUM_RINGS  = 3;
  localparam int RING_W     = 2;
  localparam int Q_ADDR_W   = RING_W + PTR_W;
  localparam int Q_DEPTH    = 4 * FIFO_DEPTH;
  localparam int OP_W       = 4;
  localparam int NPRIO_W    = 4;
  localparam int STATUS_W   = 3;
  localparam int LVL_W      = 2;
  localparam int PRIO_W     = 2;
  localparam int QNT_W      = 3;
  localparam int ENT_W      = 1 + LVL_W + PRIO_W + QNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 4'd0,
    OP_REQUEUE  = 4'd1,
    OP_SELECT   = 4'd2,
    OP_WITHDRAW = 4'd3,
    OP_SET_PRIO = 4'd4,
    OP_BOOST    = 4'd5,
    OP_TO_FCFS  = 4'd6,
    OP_TO_MLFQ  = 4'd7,
    OP_QUERY    = 4'd8
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_PRIO  = 3'd1,
    STAT_SAME_MODE = 3'd2,
    STAT_NONE      = 3'd3,
    STAT_OVERFLOW  = 3'd4
  } status_e;

  // Region codes of the queue memory: three rings and the level 2 list.
  localparam logic [RING_W-1:0] RING_FCFS = 2'd0;
  localparam logic [RING_W-1:0] RING_L0   = 2'd1;
  localparam logic [RING_W-1:0] RING_L1   = 2'd2;
  localparam logic [RING_W-1:0] RING_TOP  = 2'd3;

  localparam logic [LVL_W-1:0]  LVL_RST   = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_RST  = 2'd3;
  localparam logic [QNT_W-1:0]  QNT_RST   = 3'd1;
  localparam logic [LVL_W-1:0]  LVL_FCFS  = 2'd3;

  typedef struct packed {
    logic              run;
    logic [LVL_W-1:0]  lvl;
    logic [PRIO_W-1:0] prio;
    logic [QNT_W-1:0]  qnt;
  } slot_ent_t;

  // An entry whose valid bit is clear reads as its reset value.
  function automatic slot_ent_t ent_eff(slot_ent_t raw, logic pv, logic rv);
    slot_ent_t e;
    e.run  = rv & raw.run;
    e.lvl  = pv ? raw.lvl  : LVL_RST;
    e.prio = pv ? raw.prio : PRIO_RST;
    e.qnt  = pv ? raw.qnt  : QNT_RST;
    return e;
  endfunction

endpackage

// ===== rtl/mlfq_if.sv =====
// Request and response channel interfaces of the scheduler.
`timescale 1ns / 1ps
interface mlfq_req_if;
  import mlfq_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [SLOT_W-1:0]  slot;
  logic [NPRIO_W-1:0] new_priority;
  modport source (output valid, output op, output slot, output new_priority, input ready);
  modport sink (input valid, input op, input slot, input new_priority, output ready);
endinterface

interface mlfq_rsp_if;
  import mlfq_pkg::*;
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   chosen_slot;
  logic                found;
  logic [LVL_W-1:0]    level_out;
  logic                fcfs_active;
  logic [STATUS_W-1:0] status;
  modport source (output valid, output chosen_slot, output found, output level_out,
                  output fcfs_active, output status, input ready);
  modport sink (input valid, input chosen_slot, input found, input level_out,
                input fcfs_active, input status, output ready);
endinterface

// ===== rtl/mlfq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/mlfq_scheduler_three_level.sv =====
// Top level of the three-level MLFQ / FCFS slot scheduler.
// Add, requeue, withdraw, set_priority and query each touch at most one slot table entry.
// Select pops ring entries and scans the whole level 2 list, then shifts the later entries down over the pick;
// boost and to_fcfs scan every slot; to_mlfq moves each running FCFS entry to level 0.
// One transaction is in work at a time; the one-write, one-read slot table and queue memory set the pace.
// Reset clears control state at once; per-slot valid bits and queue counts stand in for the
// table and queue contents, so there is no clearing pass.
`timescale 1ns / 1ps
`include "mlfq_scheduler_three_level_macros.svh"
module mlfq_scheduler_three_level (
  input logic       clk_i,
  input logic       rst_ni,
  mlfq_req_if.sink  req_if,
  mlfq_rsp_if.source rsp_if
);
  import mlfq_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_DISPATCH = 15'h0002,
    S_SLOT_UPD = 15'h0004,
    S_SEL_NEXT = 15'h0008,
    S_POP_WAIT = 15'h0010,
    S_CHK      = 15'h0020,
    S_SCAN     = 15'h0040,
    S_SCAN_CHK = 15'h0080,
    S_TOP_RD   = 15'h0100,
    S_TOP_WT   = 15'h0200,
    S_TOP_CMP  = 15'h0400,
    S_SHIFT    = 15'h0800,
    S_SHIFT_WR = 15'h1000,
    S_TOP_CHK  = 15'h2000,
    S_DONE     = 15'h4000
  } state_e;

  state_e state_q, state_d;
  logic mode_q, mode_d;
  logic [NUM_RINGS-1:0][PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [NUM_RINGS-1:0][CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] top_cnt_q, top_cnt_d;
  logic [NUM_SLOTS-1:0] pv_q, pv_d, rv_q, rv_d;
  logic pv_rd_q, rv_rd_q;
  logic [RING_W-1:0] ring_q, ring_d;
  logic [CNT_W-1:0] idx_q, idx_d, best_idx_q, best_idx_d;
  logic [SLOT_W-1:0] cand_q, cand_d, best_slot_q, best_slot_d;
  logic [PRIO_W-1:0] best_prio_q, best_prio_d;
  logic have_best_q, have_best_d;

  op_e op_q, op_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [NPRIO_W-1:0] np_q, np_d;

  logic [SLOT_W-1:0] res_chosen_q, res_chosen_d;
  logic res_found_q, res_found_d;
  logic [LVL_W-1:0] res_lvl_q, res_lvl_d;
  status_e res_status_q, res_status_d;

  logic out_valid_q, out_valid_d;
  logic [SLOT_W-1:0] out_chosen_q, out_chosen_d;
  logic out_found_q, out_found_d;
  logic [LVL_W-1:0] out_lvl_q, out_lvl_d;
  logic out_fcfs_q, out_fcfs_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  logic t_re, t_we;
  logic [SLOT_W-1:0] t_raddr, t_waddr;
  slot_ent_t t_wdata, tbl_e, ne;
  logic [ENT_W-1:0] t_rdata;
  logic q_re, q_we;
  logic [Q_ADDR_W-1:0] q_raddr, q_waddr;
  logic [SLOT_W-1:0] q_wdata, q_rdata;

  logic push_en;
  logic [RING_W-1:0] push_ring;
  logic [SLOT_W-1:0] push_slot;
  logic better;

  mlfq_ram #(.WIDTH(ENT_W), .DEPTH(NUM_SLOTS)) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (t_re),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  mlfq_ram #(.WIDTH(SLOT_W), .DEPTH(Q_DEPTH)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  assign tbl_e = ent_eff(slot_ent_t'(t_rdata), pv_rd_q, rv_rd_q);
  assign better = !have_best_q || (tbl_e.prio > best_prio_q);

  assign req_if.ready       = (state_q == S_IDLE);
  assign rsp_if.valid       = out_valid_q;
  assign rsp_if.chosen_slot = out_chosen_q;
  assign rsp_if.found       = out_found_q;
  assign rsp_if.level_out   = out_lvl_q;
  assign rsp_if.fcfs_active = out_fcfs_q;
  assign rsp_if.status      = out_status_q;

  always_comb begin
    state_d = state_q;
    mode_d = mode_q;
    head_d = head_q;
    tail_d = tail_q;
    cnt_d = cnt_q;
    top_cnt_d = top_cnt_q;
    pv_d = pv_q;
    rv_d = rv_q;
    ring_d = ring_q;
    idx_d = idx_q;
    best_idx_d = best_idx_q;
    cand_d = cand_q;
    best_slot_d = best_slot_q;
    best_prio_d = best_prio_q;
    have_best_d = have_best_q;
    op_d = op_q;
    slot_d = slot_q;
    np_d = np_q;
    res_chosen_d = res_chosen_q;
    res_found_d = res_found_q;
    res_lvl_d = res_lvl_q;
    res_status_d = res_status_q;
    out_valid_d = out_valid_q && !rsp_if.ready;
    out_chosen_d = out_chosen_q;
    out_found_d = out_found_q;
    out_lvl_d = out_lvl_q;
    out_fcfs_d = out_fcfs_q;
    out_status_d = out_status_q;
    t_re = 1'b0;
    t_raddr = slot_q;
    t_we = 1'b0;
    t_waddr = slot_q;
    t_wdata = tbl_e;
    q_re = 1'b0;
    q_raddr = {ring_q, head_q[ring_q[0] ? 0 : 0]};
    q_we = 1'b0;
    q_waddr = '0;
    q_wdata = '0;
    push_en = 1'b0;
    push_ring = RING_FCFS;
    push_slot = slot_q;
    ne = tbl_e;

    case (state_q)
      S_IDLE: begin
        if (req_if.valid) begin
          op_d = op_e'(req_if.op);
          slot_d = req_if.slot;
          np_d = req_if.new_priority;
          res_chosen_d = '0;
          res_found_d = 1'b0;
          res_lvl_d = '0;
          res_status_d = STAT_OK;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_DONE;
        case (op_q)
          OP_ADD, OP_REQUEUE, OP_WITHDRAW: begin
            t_re = 1'b1;
            state_d = S_SLOT_UPD;
          end
          OP_SET_PRIO: begin
            if (np_q > NPRIO_W'(PRIO_RST)) begin
              res_status_d = STAT_BAD_PRIO;
            end else begin
              t_re = 1'b1;
              state_d = S_SLOT_UPD;
            end
          end
          OP_QUERY: begin
            if (mode_q) begin
              res_lvl_d = LVL_FCFS;
            end else begin
              t_re = 1'b1;
              state_d = S_SLOT_UPD;
            end
          end
          OP_SELECT: begin
            ring_d = mode_q ? RING_FCFS : RING_L0;
            state_d = S_SEL_NEXT;
          end
          OP_BOOST: begin
            head_d[RING_L0] = '0;
            tail_d[RING_L0] = '0;
            cnt_d[RING_L0] = '0;
            head_d[RING_L1] = '0;
            tail_d[RING_L1] = '0;
            cnt_d[RING_L1] = '0;
            top_cnt_d = '0;
            pv_d = '0;
            ring_d = RING_L0;
            idx_d = '0;
            state_d = S_SCAN;
          end
          OP_TO_FCFS: begin
            if (mode_q) begin
              res_status_d = STAT_SAME_MODE;
            end else begin
              head_d[RING_FCFS] = '0;
              tail_d[RING_FCFS] = '0;
              cnt_d[RING_FCFS] = '0;
              mode_d = 1'b1;
              ring_d = RING_FCFS;
              idx_d = '0;
              state_d = S_SCAN;
            end
          end
          OP_TO_MLFQ: begin
            if (!mode_q) begin
              res_status_d = STAT_SAME_MODE;
            end else begin
              head_d[RING_L0] = '0;
              tail_d[RING_L0] = '0;
              cnt_d[RING_L0] = '0;
              head_d[RING_L1] = '0;
              tail_d[RING_L1] = '0;
              cnt_d[RING_L1] = '0;
              top_cnt_d = '0;
              pv_d = '0;
              mode_d = 1'b0;
              ring_d = RING_FCFS;
              state_d = S_SEL_NEXT;
            end
          end
          default: ;
        endcase
      end
      S_SLOT_UPD: begin
        state_d = S_DONE;
        case (op_q)
          OP_ADD, OP_REQUEUE: begin
            ne.run = 1'b1;
            push_en = 1'b1;
            if (mode_q) begin
              push_ring = RING_FCFS;
            end else begin
              if (op_q == OP_ADD) begin
                ne.lvl = LVL_RST;
                ne.prio = PRIO_RST;
                ne.qnt = QNT_RST;
              end else begin
                ne.qnt = tbl_e.qnt - QNT_W'(1);
                if (ne.qnt == '0) begin
                  if (tbl_e.lvl < LVL_W'(2)) begin
                    ne.lvl = tbl_e.lvl + LVL_W'(1);
                  end else if (tbl_e.prio != '0) begin
                    ne.prio = tbl_e.prio - PRIO_W'(1);
                  end
                  // A fresh quantum of 2*level+1.
                  ne.qnt = {ne.lvl, 1'b1};
                end
              end
              if (ne.lvl == LVL_W'(0)) begin
                push_ring = RING_L0;
              end else if (ne.lvl == LVL_W'(1)) begin
                push_ring = RING_L1;
              end else begin
                push_ring = RING_TOP;
              end
            end
            t_we = 1'b1;
          end
          OP_WITHDRAW: begin
            ne.run = 1'b0;
            t_we = 1'b1;
          end
          OP_SET_PRIO: begin
            ne.prio = np_q[PRIO_W-1:0];
            t_we = 1'b1;
          end
          OP_QUERY: res_lvl_d = tbl_e.lvl;
          default: ;
        endcase
        t_wdata = ne;
      end
      S_SEL_NEXT: begin
        if (ring_q == RING_TOP) begin
          if (top_cnt_q != '0) begin
            idx_d = '0;
            have_best_d = 1'b0;
            state_d = S_TOP_RD;
          end else begin
            res_status_d = STAT_NONE;
            state_d = S_DONE;
          end
        end else if (cnt_q[ring_q] != '0) begin
          q_re = 1'b1;
          q_raddr = {ring_q, head_q[ring_q]};
          state_d = S_POP_WAIT;
        end else if (op_q == OP_TO_MLFQ) begin
          state_d = S_DONE;
        end else if (ring_q == RING_FCFS) begin
          res_status_d = STAT_NONE;
          state_d = S_DONE;
        end else begin
          ring_d = (ring_q == RING_L0) ? RING_L1 : RING_TOP;
        end
      end
      S_POP_WAIT: begin
        cand_d = q_rdata;
        head_d[ring_q] = head_q[ring_q] + PTR_W'(1);
        cnt_d[ring_q] = cnt_q[ring_q] - CNT_W'(1);
        t_re = 1'b1;
        t_raddr = q_rdata;
        state_d = S_CHK;
      end
      S_CHK: begin
        state_d = S_SEL_NEXT;
        if (op_q == OP_TO_MLFQ) begin
          push_en = tbl_e.run;
          push_ring = RING_L0;
          push_slot = cand_q;
        end else if (tbl_e.run) begin
          res_found_d = 1'b1;
          res_chosen_d = cand_q;
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        t_re = 1'b1;
        t_raddr = idx_q[SLOT_W-1:0];
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        push_en = tbl_e.run;
        push_ring = ring_q;
        push_slot = idx_q[SLOT_W-1:0];
        if (idx_q[SLOT_W-1:0] == SLOT_W'(NUM_SLOTS - 1)) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + CNT_W'(1);
          state_d = S_SCAN;
        end
      end
      S_TOP_RD: begin
        q_re = 1'b1;
        q_raddr = {RING_TOP, idx_q[PTR_W-1:0]};
        state_d = S_TOP_WT;
      end
      S_TOP_WT: begin
        cand_d = q_rdata;
        t_re = 1'b1;
        t_raddr = q_rdata;
        state_d = S_TOP_CMP;
      end
      S_TOP_CMP: begin
        // Strictly higher priority wins, so the earliest entry keeps a tie.
        if (better) begin
          best_idx_d = idx_q;
          best_slot_d = cand_q;
          best_prio_d = tbl_e.prio;
          have_best_d = 1'b1;
        end
        if (idx_q + CNT_W'(1) >= top_cnt_q) begin
          idx_d = better ? idx_q : best_idx_q;
          state_d = S_SHIFT;
        end else begin
          idx_d = idx_q + CNT_W'(1);
          state_d = S_TOP_RD;
        end
      end
      S_SHIFT: begin
        if (idx_q + CNT_W'(1) < top_cnt_q) begin
          q_re = 1'b1;
          q_raddr = {RING_TOP, PTR_W'(idx_q + CNT_W'(1))};
          state_d = S_SHIFT_WR;
        end else begin
          top_cnt_d = top_cnt_q - CNT_W'(1);
          t_re = 1'b1;
          t_raddr = best_slot_q;
          state_d = S_TOP_CHK;
        end
      end
      S_SHIFT_WR: begin
        q_we = 1'b1;
        q_waddr = {RING_TOP, idx_q[PTR_W-1:0]};
        q_wdata = q_rdata;
        idx_d = idx_q + CNT_W'(1);
        state_d = S_SHIFT;
      end
      S_TOP_CHK: begin
        if (tbl_e.run) begin
          res_found_d = 1'b1;
          res_chosen_d = best_slot_q;
          state_d = S_DONE;
        end else begin
          state_d = S_SEL_NEXT;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_if.ready) begin
          out_valid_d = 1'b1;
          out_chosen_d = res_chosen_q;
          out_found_d = res_found_q;
          out_lvl_d = res_lvl_q;
          out_fcfs_d = mode_q;
          out_status_d = res_status_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (t_we) begin
      pv_d[t_waddr] = 1'b1;
      rv_d[t_waddr] = 1'b1;
    end

    if (push_en) begin
      if (push_ring == RING_TOP) begin
        if (top_cnt_q < CNT_W'(NUM_SLOTS)) begin
          q_we = 1'b1;
          q_waddr = {RING_TOP, top_cnt_q[PTR_W-1:0]};
          q_wdata = push_slot;
          top_cnt_d = top_cnt_q + CNT_W'(1);
        end else begin
          res_status_d = STAT_OVERFLOW;
        end
      end else if (cnt_q[push_ring] < CNT_W'(FIFO_DEPTH)) begin
        q_we = 1'b1;
        q_waddr = {push_ring, tail_q[push_ring]};
        q_wdata = push_slot;
        tail_d[push_ring] = tail_q[push_ring] + PTR_W'(1);
        cnt_d[push_ring] = cnt_q[push_ring] + CNT_W'(1);
      end else begin
        res_status_d = STAT_OVERFLOW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= 1'b1;
      head_q <= '0;
      tail_q <= '0;
      cnt_q <= '0;
      top_cnt_q <= '0;
      pv_q <= '0;
      rv_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q <= mode_d;
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q <= cnt_d;
      top_cnt_q <= top_cnt_d;
      pv_q <= pv_d;
      rv_q <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (t_re) begin
      pv_rd_q <= pv_q[t_raddr];
      rv_rd_q <= rv_q[t_raddr];
    end
    ring_q <= ring_d;
    idx_q <= idx_d;
    best_idx_q <= best_idx_d;
    cand_q <= cand_d;
    best_slot_q <= best_slot_d;
    best_prio_q <= best_prio_d;
    have_best_q <= have_best_d;
    op_q <= op_d;
    slot_q <= slot_d;
    np_q <= np_d;
    res_chosen_q <= res_chosen_d;
    res_found_q <= res_found_d;
    res_lvl_q <= res_lvl_d;
    res_status_q <= res_status_d;
    out_chosen_q <= out_chosen_d;
    out_found_q <= out_found_d;
    out_lvl_q <= out_lvl_d;
    out_fcfs_q <= out_fcfs_d;
    out_status_q <= out_status_d;
  end

  `MLFQ_ASSERT(a_ring_occupancy, clk_i, rst_ni, (cnt_q[0] <= CNT_W'(FIFO_DEPTH)) && (cnt_q[1] <= CNT_W'(FIFO_DEPTH)) && (cnt_q[2] <= CNT_W'(FIFO_DEPTH)) && (top_cnt_q <= CNT_W'(NUM_SLOTS)), "queue occupancy above capacity")
  `MLFQ_ASSERT(a_ring_ptrs, clk_i, rst_ni, (PTR_W'(tail_q[0] - head_q[0]) == cnt_q[0][PTR_W-1:0]) && (PTR_W'(tail_q[1] - head_q[1]) == cnt_q[1][PTR_W-1:0]) && (PTR_W'(tail_q[2] - head_q[2]) == cnt_q[2][PTR_W-1:0]), "ring pointers disagree with count")
  `MLFQ_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, req_if.valid && req_if.ready |=> state_q != S_IDLE, "accepted transaction not started")
  `MLFQ_ASSERT(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result loaded outside the done state")

endmodule
